### hdl/ames_pkg.sv
// shared types and constants for the adjacency matrix edge store
// no dependencies
package ames_pkg;

    localparam int MAX_NODES_DEF  = 64;
    localparam int LABEL_BITS_DEF = 8;

    localparam logic [3:0] K_ADD    = 4'd0;
    localparam logic [3:0] K_REMOVE = 4'd1;
    localparam logic [3:0] K_SETW   = 4'd2;
    localparam logic [3:0] K_GETW   = 4'd3;
    localparam logic [3:0] K_EXISTS = 4'd4;
    localparam logic [3:0] K_SETNL  = 4'd5;
    localparam logic [3:0] K_GETNL  = 4'd6;
    localparam logic [3:0] K_SETEL  = 4'd7;
    localparam logic [3:0] K_GETEL  = 4'd8;
    localparam logic [3:0] K_FIRST  = 4'd9;
    localparam logic [3:0] K_NEXT   = 4'd10;
    localparam logic [3:0] K_RESIZE = 4'd11;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_SHRINK = 2'd2;
    localparam logic [1:0] ST_END    = 2'd3;

    typedef struct packed {
        logic clear_en;
        logic load_in;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_more;
    } dp_sts_t;

endpackage

### hdl/ames_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ames_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/ames_ctrl.sv
// controller state machine for the edge store
// depends on ames_pkg
module ames_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output ames_pkg::dp_cmd_t cmd,
    input  ames_pkg::dp_sts_t sts
);
    import ames_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.clear_en = (state_reg == S_CLEAR);
        cmd.load_in  = (state_reg == S_IDLE) && in_valid;
        cmd.step     = (state_reg == S_EXEC) && sts.scan_more;
        cmd.commit   = (state_reg == S_EXEC) && !sts.scan_more && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (sts.scan_more)
                begin
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not shown after commit");
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (state_reg == S_READ))
        else $error("accepted item did not start a read");
    a_commit_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && cmd.step))
        else $error("commit and scan step together");
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_en && in_ready))
        else $error("ready during clearing pass");

endmodule

### hdl/ames_dp.sv
// datapath for the edge store: matrix and label rams, scan logic, result registers
// depends on ames_pkg and ames_ram
module ames_dp #(
    parameter int MAX_NODES  = ames_pkg::MAX_NODES_DEF,
    parameter int LABEL_BITS = ames_pkg::LABEL_BITS_DEF,
    localparam int IW = $clog2(MAX_NODES),
    localparam int NW = IW + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ames_pkg::dp_cmd_t        cmd,
    output ames_pkg::dp_sts_t        sts,
    input  logic [3:0]               kind,
    input  logic signed [NW-1:0]     src_node,
    input  logic signed [NW-1:0]     dst_node,
    input  logic [31:0]              data_value,
    input  logic [NW-1:0]            new_count,
    output logic [1:0]               status,
    output logic                     found,
    output logic [31:0]              read_value,
    output logic signed [NW-1:0]     edge_src,
    output logic signed [NW-1:0]     edge_dst
);
    import ames_pkg::*;

    localparam int AW = 2 * IW;

    logic [3:0]     kind_reg;
    logic [NW-1:0]  src_reg, dst_reg;
    logic [31:0]    data_reg;
    logic [NW-1:0]  newc_reg;
    logic [IW-1:0]  row_reg, row_next;
    logic [NW-1:0]  col_reg, col_next;
    logic [NW-1:0]  count_reg, count_next;
    logic [MAX_NODES-1:0] rvalid_reg, rvalid_next;
    logic [AW-1:0]  clr_reg;

    logic [1:0]     status_reg, status_next;
    logic           found_reg, found_next;
    logic [31:0]    rv_reg, rv_next;
    logic [NW-1:0]  es_reg, es_next, ed_reg, ed_next;

    logic [MAX_NODES-1:0]  prow, row_eff, pwdata, hits;
    logic [31:0]           wrd;
    logic [LABEL_BITS-1:0] elrd, nlrd;
    logic [AW-1:0]         entry_addr;
    logic                  p_we, w_we, el_we, nl_we;
    logic [31:0]           w_wd;
    logic [LABEL_BITS-1:0] el_wd, nl_wd;
    logic                  src_ok, dst_ok, edge_ok, hit, last_row, scan_err;
    logic [1:0]            scan_st;
    logic [IW-1:0]         hit_idx;
    logic                  is_scan;

    function automatic logic in_rng(logic [NW-1:0] v, logic [NW-1:0] cnt);
        return !v[NW-1] && ({1'b0, v[IW-1:0]} < cnt);
    endfunction

    assign entry_addr = {src_reg[IW-1:0], dst_reg[IW-1:0]};
    assign row_eff = rvalid_reg[row_reg] ? prow : '0;
    assign src_ok  = in_rng(src_reg, count_reg);
    assign dst_ok  = in_rng(dst_reg, count_reg);
    assign edge_ok = src_ok && dst_ok;
    assign is_scan = (kind_reg == K_FIRST) || (kind_reg == K_NEXT);
    assign last_row = ((NW)'({1'b0, row_reg}) + NW'(1)) >= count_reg;

    always_comb
    begin
        hits    = '0;
        hit_idx = '0;
        for (int j = 0; j < MAX_NODES; j++)
        begin
            hits[j] = row_eff[j] && (NW'(j) >= col_reg) && (NW'(j) < count_reg);
        end
        for (int j = MAX_NODES - 1; j >= 0; j--)
        begin
            if (hits[j])
            begin
                hit_idx = IW'(j);
            end
        end
    end
    assign hit = |hits;

    always_comb
    begin
        scan_err = 1'b0;
        scan_st  = ST_OK;
        if (kind_reg == K_NEXT)
        begin
            if (src_reg == '1 && dst_reg == '1)
            begin
                scan_err = 1'b1;
                scan_st  = ST_END;
            end
            else if (!src_ok || !(dst_reg == '1 || dst_ok))
            begin
                scan_err = 1'b1;
                scan_st  = ST_RANGE;
            end
        end
    end

    assign sts.scan_more  = is_scan && !scan_err && !hit && !last_row;
    assign sts.clear_done = (clr_reg == '1);

    always_comb
    begin
        pwdata = row_eff;
        pwdata[dst_reg[IW-1:0]] = (kind_reg == K_ADD);
    end

    always_comb
    begin
        status_next = ST_OK;
        found_next  = 1'b0;
        rv_next     = '0;
        es_next     = '1;
        ed_next     = '1;
        count_next  = count_reg;
        rvalid_next = rvalid_reg;
        p_we        = 1'b0;
        w_we        = 1'b0;
        el_we       = 1'b0;
        nl_we       = 1'b0;
        w_wd        = data_reg;
        el_wd       = data_reg[LABEL_BITS-1:0];
        nl_wd       = data_reg[LABEL_BITS-1:0];
        case (kind_reg)
            K_ADD, K_REMOVE, K_SETW, K_GETW, K_EXISTS, K_SETEL, K_GETEL:
            begin
                if (!edge_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    case (kind_reg)
                        K_ADD:
                        begin
                            p_we  = 1'b1;
                            w_we  = 1'b1;
                            el_we = 1'b1;
                            el_wd = '0;
                            rvalid_next[row_reg] = 1'b1;
                        end
                        K_REMOVE:
                        begin
                            p_we = 1'b1;
                            rvalid_next[row_reg] = 1'b1;
                        end
                        K_SETW:  w_we = 1'b1;
                        K_GETW:  rv_next = wrd;
                        K_EXISTS: found_next = row_eff[dst_reg[IW-1:0]];
                        K_SETEL: el_we = 1'b1;
                        default: rv_next = 32'(elrd);
                    endcase
                end
            end
            K_SETNL, K_GETNL:
            begin
                if (!src_ok)
                begin
                    status_next = ST_RANGE;
                end
                else if (kind_reg == K_SETNL)
                begin
                    nl_we = 1'b1;
                end
                else
                begin
                    rv_next = 32'(nlrd);
                end
            end
            K_FIRST, K_NEXT:
            begin
                status_next = scan_st;
                if (!scan_err && hit)
                begin
                    found_next = 1'b1;
                    es_next    = {1'b0, row_reg};
                    ed_next    = {1'b0, hit_idx};
                end
            end
            K_RESIZE:
            begin
                if (newc_reg > NW'(MAX_NODES))
                begin
                    status_next = ST_RANGE;
                end
                else if (newc_reg < count_reg)
                begin
                    status_next = ST_SHRINK;
                end
                else
                begin
                    count_next  = newc_reg;
                    rvalid_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.load_in)
        begin
            row_next = (kind == K_FIRST) ? '0 : src_node[IW-1:0];
            col_next = (kind == K_FIRST) ? '0 : NW'(dst_node + NW'(1));
        end
        else if (cmd.step)
        begin
            row_next = row_reg + IW'(1);
            col_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= kind;
            src_reg  <= src_node;
            dst_reg  <= dst_node;
            data_reg <= data_value;
            newc_reg <= new_count;
        end
        row_reg <= row_next;
        col_reg <= col_next;
        if (cmd.commit)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            rv_reg     <= rv_next;
            es_reg     <= es_next;
            ed_reg     <= ed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rvalid_reg <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                count_reg  <= count_next;
                rvalid_reg <= rvalid_next;
            end
        end
    end

    ames_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_present (
        .clk   (clk),
        .we    (cmd.commit && p_we),
        .waddr (row_reg),
        .wdata (pwdata),
        .raddr (row_reg),
        .rdata (prow)
    );

    ames_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_weight (
        .clk   (clk),
        .we    (cmd.clear_en || (cmd.commit && w_we)),
        .waddr (cmd.clear_en ? clr_reg : entry_addr),
        .wdata (cmd.clear_en ? 32'd0 : w_wd),
        .raddr (entry_addr),
        .rdata (wrd)
    );

    ames_ram #(.WIDTH(LABEL_BITS), .DEPTH(1 << AW)) u_elabel (
        .clk   (clk),
        .we    (cmd.clear_en || (cmd.commit && el_we)),
        .waddr (cmd.clear_en ? clr_reg : entry_addr),
        .wdata (cmd.clear_en ? '0 : el_wd),
        .raddr (entry_addr),
        .rdata (elrd)
    );

    ames_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_NODES)) u_nlabel (
        .clk   (clk),
        .we    (cmd.clear_en || (cmd.commit && nl_we)),
        .waddr (cmd.clear_en ? clr_reg[IW-1:0] : src_reg[IW-1:0]),
        .wdata (cmd.clear_en ? '0 : nl_wd),
        .raddr (src_reg[IW-1:0]),
        .rdata (nlrd)
    );

    assign status     = status_reg;
    assign found      = found_reg;
    assign read_value = rv_reg;
    assign edge_src   = es_reg;
    assign edge_dst   = ed_reg;

endmodule

### hdl/adjacency_matrix_edge_store_unit.sv
// an accepted request goes through READ and EXEC before its result is registered;
// a scan goes back to READ for each further row, one row per read of the present ram;
// EXEC waits while a result is still untaken; a new request is accepted only in IDLE
// reset: asynchronous; then a clearing pass over every ram address zeroes the
// weight and label rams with ready low; present marks are cleared by per-row valid bits
// depends on ames_pkg, ames_ctrl, ames_dp
module adjacency_matrix_edge_store_unit #(
    parameter int MAX_NODES  = ames_pkg::MAX_NODES_DEF,
    parameter int LABEL_BITS = ames_pkg::LABEL_BITS_DEF,
    localparam int NW = $clog2(MAX_NODES) + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           kind,
    input  logic signed [NW-1:0] src_node,
    input  logic signed [NW-1:0] dst_node,
    input  logic [31:0]          data_value,
    input  logic [NW-1:0]        new_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic                 found,
    output logic [31:0]          read_value,
    output logic signed [NW-1:0] edge_src,
    output logic signed [NW-1:0] edge_dst
);
    import ames_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    ames_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ames_dp #(.MAX_NODES(MAX_NODES), .LABEL_BITS(LABEL_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .data_value (data_value),
        .new_count  (new_count),
        .status     (status),
        .found      (found),
        .read_value (read_value),
        .edge_src   (edge_src),
        .edge_dst   (edge_dst)
    );

endmodule

### tb/sv/tb_top.sv
// self-checking bench for adjacency_matrix_edge_store_unit: a shadow graph predicts each answer
// directed requests then random graph traffic with random stalls on both channels
// depends on ames_pkg and the store rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ames_pkg::*;

    localparam int NODES     = 64;
    localparam int LIMIT     = 2000000;
    localparam int DRAIN     = 2 * NODES + 20;
    localparam int CALM_TAIL = 200;

    typedef struct {
        logic [3:0]        kind;
        logic signed [6:0] src;
        logic signed [6:0] dst;
        logic [31:0]       data;
        logic [6:0]        cnt;
    } graph_req_t;

    typedef struct {
        logic [1:0]        status;
        logic              found;
        logic [31:0]       value;
        logic signed [6:0] esrc;
        logic signed [6:0] edst;
    } graph_ans_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [3:0] kind;
    logic signed [6:0] src_node;
    logic signed [6:0] dst_node;
    logic [31:0] data_value;
    logic [6:0] new_count;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic found;
    logic [31:0] read_value;
    logic signed [6:0] edge_src;
    logic signed [6:0] edge_dst;

    graph_req_t pending_requests[$];
    graph_ans_t expected_answers[$];
    graph_req_t on_wire;

    int  shadow_count;
    bit  shadow_present[NODES*NODES];
    logic [31:0] shadow_weight[NODES*NODES];
    logic [7:0]  shadow_elabel[NODES*NODES];
    logic [7:0]  shadow_nlabel[NODES];

    int  errors;
    int  in_gap;
    int  out_gap;
    int  cycles;
    int  gen_count;

    adjacency_matrix_edge_store_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .src_node(src_node), .dst_node(dst_node),
        .data_value(data_value), .new_count(new_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .read_value(read_value),
        .edge_src(edge_src), .edge_dst(edge_dst)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit node_ok(int v);
        return v >= 0 && v < shadow_count;
    endfunction

    function automatic graph_ans_t graph_answer(graph_req_t r);
        graph_ans_t a;
        int s;
        int d;
        int c;
        int j;
        bit hit;
        a.status = ST_OK;
        a.found  = 1'b0;
        a.value  = 32'd0;
        a.esrc   = -7'sd1;
        a.edst   = -7'sd1;
        s = r.src;
        d = r.dst;
        hit = 1'b0;
        case (r.kind)
            K_ADD, K_REMOVE, K_SETW, K_GETW, K_EXISTS, K_SETEL, K_GETEL:
            begin
                if (!(node_ok(s) && node_ok(d)))
                    a.status = ST_RANGE;
                else
                begin
                    c = s * NODES + d;
                    case (r.kind)
                        K_ADD:
                        begin
                            shadow_present[c] = 1'b1;
                            shadow_weight[c]  = r.data;
                            shadow_elabel[c]  = 8'd0;
                        end
                        K_REMOVE: shadow_present[c] = 1'b0;
                        K_SETW:   shadow_weight[c] = r.data;
                        K_GETW:   a.value = shadow_weight[c];
                        K_EXISTS: a.found = shadow_present[c];
                        K_SETEL:  shadow_elabel[c] = r.data[7:0];
                        default:  a.value = {24'd0, shadow_elabel[c]};
                    endcase
                end
            end
            K_SETNL, K_GETNL:
            begin
                if (!node_ok(s))
                    a.status = ST_RANGE;
                else if (r.kind == K_SETNL)
                    shadow_nlabel[s] = r.data[7:0];
                else
                    a.value = {24'd0, shadow_nlabel[s]};
            end
            K_FIRST, K_NEXT:
            begin
                if (r.kind == K_FIRST)
                begin
                    s = 0;
                    d = -1;
                end
                if (r.kind == K_NEXT && s == -1 && d == -1)
                    a.status = ST_END;
                else if (r.kind == K_NEXT && (!node_ok(s) || !(d == -1 || node_ok(d))))
                    a.status = ST_RANGE;
                else
                begin
                    for (int i = s; i < shadow_count && !hit; i++)
                    begin
                        for (j = (i == s) ? d + 1 : 0; j < shadow_count && !hit; j++)
                        begin
                            if (shadow_present[i*NODES+j])
                            begin
                                hit    = 1'b1;
                                a.found = 1'b1;
                                a.esrc = 7'(i);
                                a.edst = 7'(j);
                            end
                        end
                    end
                end
            end
            K_RESIZE:
            begin
                if (r.cnt > NODES)
                    a.status = ST_RANGE;
                else if (r.cnt < shadow_count)
                    a.status = ST_SHRINK;
                else
                begin
                    shadow_count = r.cnt;
                    foreach (shadow_present[k]) shadow_present[k] = 1'b0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic void push_req(logic [3:0] k, int s, int d, logic [31:0] v, int n);
        graph_req_t r;
        r.kind = k;
        r.src  = 7'(s);
        r.dst  = 7'(d);
        r.data = v;
        r.cnt  = 7'(n);
        pending_requests.push_back(r);
    endfunction

    function automatic int pick_node();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, gen_count - 1);
        else if (r < 92)
            return -1;
        else
            return int'($urandom_range(0, 127)) - 64;
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= 4'd0;
            src_node   <= 7'sd0;
            dst_node   <= 7'sd0;
            data_value <= 32'd0;
            new_count  <= 7'd0;
            in_gap     = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_answers.push_back(graph_answer(on_wire));
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                on_wire = pending_requests.pop_front();
                kind       <= on_wire.kind;
                src_node   <= on_wire.src;
                dst_node   <= on_wire.dst;
                data_value <= on_wire.data;
                new_count  <= on_wire.cnt;
                in_valid   <= 1'b1;
                if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                    in_gap = $urandom_range(1, 8);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        graph_ans_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer out: status=%0d", status);
                end
                else
                begin
                    e = expected_answers.pop_front();
                    if (status !== e.status || found !== e.found || read_value !== e.value
                        || edge_src !== e.esrc || edge_dst !== e.edst)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                                e.status, e.found, e.value, e.esrc, e.edst,
                                status, found, read_value, edge_src, edge_dst);
                    end
                end
            end
            if (out_gap > 0)
                out_gap--;
            else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                out_gap = $urandom_range(1, 8);
            out_ready <= (out_gap == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int r;
        int s;
        int d;
        int n;
        errors = 0;
        cycles = 0;
        shadow_count = 0;
        foreach (shadow_present[k])
        begin
            shadow_present[k] = 1'b0;
            shadow_weight[k]  = 32'd0;
            shadow_elabel[k]  = 8'd0;
        end
        foreach (shadow_nlabel[k]) shadow_nlabel[k] = 8'd0;

        // directed: empty graph, range and shrink errors, label masking, scan edges
        push_req(K_ADD, 0, 0, 32'h1, 0);
        push_req(K_FIRST, 0, 0, 0, 0);
        push_req(K_NEXT, -1, -1, 0, 0);
        push_req(K_RESIZE, 0, 0, 0, 65);
        push_req(K_RESIZE, 0, 0, 0, 4);
        push_req(K_RESIZE, 0, 0, 0, 2);
        push_req(K_ADD, 0, 1, 32'hffff_ffff, 0);
        push_req(K_ADD, 3, 3, 32'h0, 0);
        push_req(K_GETW, 0, 1, 0, 0);
        push_req(K_EXISTS, 0, 1, 0, 0);
        push_req(K_EXISTS, 1, 0, 0, 0);
        push_req(K_SETW, 2, 2, 32'hdead_beef, 0);
        push_req(K_GETW, 2, 2, 0, 0);
        push_req(K_SETEL, 0, 1, 32'hffff_ffff, 0);
        push_req(K_GETEL, 0, 1, 0, 0);
        push_req(K_SETNL, 3, 0, 32'h1234_56a5, 0);
        push_req(K_GETNL, 3, 0, 0, 0);
        push_req(K_GETNL, 4, 0, 0, 0);
        push_req(K_SETNL, -1, 0, 32'h7, 0);
        push_req(K_FIRST, 0, 0, 0, 0);
        push_req(K_NEXT, 0, 1, 0, 0);
        push_req(K_NEXT, 3, 3, 0, 0);
        push_req(K_NEXT, 4, 0, 0, 0);
        push_req(K_NEXT, 0, -2, 0, 0);
        push_req(4'd13, 63, -64, 32'hffff_ffff, 127);
        push_req(K_RESIZE, 0, 0, 0, 8);
        push_req(K_GETW, 0, 1, 0, 0);
        push_req(K_EXISTS, 0, 1, 0, 0);
        gen_count = 8;

        for (int i = 0; i < 1620; i++)
        begin
            r = $urandom_range(0, 99);
            s = pick_node();
            d = pick_node();
            n = $urandom_range(0, 127);
            if (i == 1100)
            begin
                push_req(K_RESIZE, s, d, pick_data(), NODES);
                gen_count = NODES;
            end
            else if (r < 25)
                push_req(K_ADD, s, d, pick_data(), n);
            else if (r < 33)
                push_req(K_REMOVE, s, d, pick_data(), n);
            else if (r < 39)
                push_req(K_SETW, s, d, pick_data(), n);
            else if (r < 47)
                push_req(K_GETW, s, d, pick_data(), n);
            else if (r < 57)
                push_req(K_EXISTS, s, d, pick_data(), n);
            else if (r < 61)
                push_req(K_SETNL, s, d, pick_data(), n);
            else if (r < 65)
                push_req(K_GETNL, s, d, pick_data(), n);
            else if (r < 70)
                push_req(K_SETEL, s, d, pick_data(), n);
            else if (r < 75)
                push_req(K_GETEL, s, d, pick_data(), n);
            else if (r < 80)
                push_req(K_FIRST, s, d, pick_data(), n);
            else if (r < 95)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    s = -1;
                    d = -1;
                end
                else if ($urandom_range(0, 2) == 0)
                    d = -1;
                push_req(K_NEXT, s, d, pick_data(), n);
            end
            else if (r < 98)
            begin
                if ($urandom_range(0, 3) != 0)
                    n = gen_count + $urandom_range(0, 3);
                if (n > NODES && $urandom_range(0, 1) == 0)
                    n = NODES;
                if (n <= NODES && n >= gen_count)
                    gen_count = n;
                push_req(K_RESIZE, s, d, pick_data(), n);
            end
            else
                push_req(4'($urandom_range(12, 15)), s, d, pick_data(), n);
        end

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### files.f
hdl/ames_pkg.sv
hdl/ames_ram.sv
hdl/ames_ctrl.sv
hdl/ames_dp.sv
hdl/adjacency_matrix_edge_store_unit.sv
tb/sv/tb_top.sv
